>>> design/scro_pkg.sv
// Package for the sparse column-to-row order core: widths, codes, controller states.
// No dependencies; used by every file of the core but scro_stream_if.
package scro_pkg;
    localparam int DEF_MAX_NONZEROS = 1024;
    localparam int DEF_MAX_COLS     = 256;
    localparam int DEF_MAX_ROWS     = 256;

    localparam int CMD_W  = 2;
    localparam int IDX_W  = 11;
    localparam int VAL_W  = 64;
    localparam int ROW_W  = 9;
    localparam int COL_W  = 9;
    localparam int POS_W  = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 11;

    localparam logic [CMD_W-1:0] CMD_LOAD_PTR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_NZ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FETCH    = 2'd2;

    localparam logic [1:0] KIND_ROW_PTR = 2'd0;
    localparam logic [1:0] KIND_ENTRY   = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_NNZ  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE, S_ROWCHK, S_SCAN_RD, S_SCAN_CHK, S_COL_RD, S_COL_CHK, S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_ptr;
        logic load_nz;
        logic restart;
        logic emit_end;
        logic emit_hdr;
        logic next_row;
        logic scan_rd;
        logic scan_adv;
        logic col_rd;
        logic col_adv;
        logic emit_entry;
        logic out_take;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic row_past_end;
        logic hdr_pending;
        logic scan_done;
        logic row_match;
        logic col_more;
        logic out_full;
    } t_status;
endpackage

>>> design/scro_stream_if.sv
// Valid/ready channel with a parameterized payload.
// Depends on nothing; top-level ports, instanced by the test environment.
interface scro_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> design/scro_ctrl.sv
// Controller state machine for the sparse column-to-row order core.
// Depends on scro_pkg for state and command/status types.
module scro_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic [scro_pkg::CMD_W-1:0] i_cmd,
    output logic                  o_in_ready,
    input  scro_pkg::t_status     i_status,
    input  logic                  i_out_ready,
    output scro_pkg::t_cmd        o_cmd
);
    scro_pkg::t_state r_state, n_state;
    logic accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scro_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == scro_pkg::S_IDLE) && !i_status.out_full;
    assign accept = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.out_take = i_status.out_full && i_out_ready;
        unique case (r_state)
            scro_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd)
                        scro_pkg::CMD_LOAD_PTR: begin
                            o_cmd.load_ptr = 1'b1;
                            o_cmd.restart  = 1'b1;
                        end
                        scro_pkg::CMD_LOAD_NZ: begin
                            o_cmd.load_nz = 1'b1;
                            o_cmd.restart = 1'b1;
                        end
                        scro_pkg::CMD_FETCH: begin
                            n_state = scro_pkg::S_ROWCHK;
                        end
                        default: ;
                    endcase
                end
            end
            scro_pkg::S_ROWCHK: begin
                priority if (i_status.row_past_end) begin
                    o_cmd.emit_end = 1'b1;
                    n_state = scro_pkg::S_IDLE;
                end else if (i_status.hdr_pending) begin
                    o_cmd.emit_hdr = 1'b1;
                    n_state = scro_pkg::S_IDLE;
                end else begin
                    n_state = scro_pkg::S_SCAN_RD;
                end
            end
            scro_pkg::S_SCAN_RD: begin
                if (i_status.scan_done) begin
                    o_cmd.next_row = 1'b1;
                    n_state = scro_pkg::S_ROWCHK;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_state = scro_pkg::S_SCAN_CHK;
                end
            end
            scro_pkg::S_SCAN_CHK: begin
                if (i_status.row_match) begin
                    n_state = scro_pkg::S_COL_RD;
                end else begin
                    o_cmd.scan_adv = 1'b1;
                    n_state = scro_pkg::S_SCAN_RD;
                end
            end
            scro_pkg::S_COL_RD: begin
                o_cmd.col_rd = 1'b1;
                n_state = scro_pkg::S_COL_CHK;
            end
            scro_pkg::S_COL_CHK: begin
                if (i_status.col_more) begin
                    o_cmd.col_adv = 1'b1;
                    n_state = scro_pkg::S_COL_RD;
                end else begin
                    n_state = scro_pkg::S_OUT;
                end
            end
            scro_pkg::S_OUT: begin
                o_cmd.emit_entry = 1'b1;
                n_state = scro_pkg::S_IDLE;
            end
            default: n_state = scro_pkg::S_IDLE;
        endcase
    end
endmodule

>>> design/scro_datapath.sv
// Datapath: pointer and nonzero memories, scan counters and output register.
// Depends on scro_pkg for widths, codes and command/status types.
module scro_datapath #(
    parameter int MAX_NONZEROS = scro_pkg::DEF_MAX_NONZEROS,
    parameter int MAX_COLS     = scro_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS     = scro_pkg::DEF_MAX_ROWS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  scro_pkg::t_cmd                i_cmd,
    output scro_pkg::t_status             o_status,
    input  logic [scro_pkg::IDX_W-1:0]    i_index_value,
    input  logic [scro_pkg::VAL_W-1:0]    i_value_bits,
    input  logic                          i_cfg_we,
    input  logic [scro_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [scro_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output logic                          o_out_valid,
    output logic [1:0]                    o_kind,
    output logic [scro_pkg::ROW_W-1:0]    o_row,
    output logic [scro_pkg::COL_W-1:0]    o_col,
    output logic [scro_pkg::POS_W-1:0]    o_position,
    output logic [scro_pkg::VAL_W-1:0]    o_value_out
);
    localparam int PTR_DEPTH = MAX_COLS + 2;
    localparam int NZ_DEPTH  = MAX_NONZEROS + 1;
    localparam int PA_W = $clog2(PTR_DEPTH);
    localparam int NA_W = $clog2(NZ_DEPTH);
    localparam int CW = 18;  // wide enough for any count up to 65537

    logic [scro_pkg::IDX_W-1:0] ptr_mem [PTR_DEPTH];
    logic [scro_pkg::ROW_W-1:0] row_mem [NZ_DEPTH];
    logic [scro_pkg::VAL_W-1:0] val_mem [NZ_DEPTH];

    logic [scro_pkg::ROW_W-1:0] r_num_rows;
    logic [scro_pkg::COL_W-1:0] r_num_cols;
    logic [scro_pkg::IDX_W-1:0] r_num_nnz;
    logic [CW-1:0] r_ptr_cnt, r_nz_cnt;
    logic [CW-1:0] r_emit_row, r_scan_idx, r_scan_col;
    logic [scro_pkg::POS_W-1:0] r_out_pos;
    logic [scro_pkg::ROW_W-1:0] r_rd_row;
    logic [scro_pkg::VAL_W-1:0] r_rd_val;
    logic [scro_pkg::IDX_W-1:0] r_rd_ptr;
    logic r_ptr_forced, r_ptr_zero;

    logic [CW-1:0] eff_rows, eff_cols, eff_nnz, next_col;
    logic [scro_pkg::IDX_W-1:0] ptr_val;

    assign eff_rows = ({{(CW-scro_pkg::ROW_W){1'b0}}, r_num_rows} > CW'(MAX_ROWS))
                      ? CW'(MAX_ROWS) : {{(CW-scro_pkg::ROW_W){1'b0}}, r_num_rows};
    assign eff_cols = ({{(CW-scro_pkg::COL_W){1'b0}}, r_num_cols} > CW'(MAX_COLS))
                      ? CW'(MAX_COLS) : {{(CW-scro_pkg::COL_W){1'b0}}, r_num_cols};
    assign eff_nnz  = ({{(CW-scro_pkg::IDX_W){1'b0}}, r_num_nnz} > CW'(MAX_NONZEROS))
                      ? CW'(MAX_NONZEROS) : {{(CW-scro_pkg::IDX_W){1'b0}}, r_num_nnz};
    assign next_col = r_scan_col + CW'(1);

    // memory writes and registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_ptr && r_ptr_cnt < CW'(MAX_COLS + 1)) begin
            ptr_mem[PA_W'(r_ptr_cnt + CW'(1))] <= i_index_value;
        end
        if (i_cmd.load_nz && r_nz_cnt < CW'(MAX_NONZEROS)) begin
            row_mem[NA_W'(r_nz_cnt + CW'(1))] <= i_index_value[scro_pkg::ROW_W-1:0];
            val_mem[NA_W'(r_nz_cnt + CW'(1))] <= i_value_bits;
        end
        if (i_cmd.scan_rd) begin
            r_rd_row <= row_mem[NA_W'(r_scan_idx)];
            r_rd_val <= val_mem[NA_W'(r_scan_idx)];
        end
        if (i_cmd.col_rd) begin
            r_rd_ptr     <= ptr_mem[PA_W'(next_col)];
            r_ptr_forced <= (next_col == eff_cols + CW'(1));
            r_ptr_zero   <= (next_col > CW'(MAX_COLS + 1));
        end
    end

    assign ptr_val = r_ptr_forced ? scro_pkg::IDX_W'(eff_nnz + CW'(1))
                   : (r_ptr_zero ? '0 : r_rd_ptr);

    always_comb begin
        o_status.row_past_end = r_emit_row > eff_rows;
        o_status.hdr_pending  = (r_scan_idx == '0);
        o_status.scan_done    = r_scan_idx > eff_nnz;
        o_status.row_match    = ({{(CW-scro_pkg::ROW_W){1'b0}}, r_rd_row} == r_emit_row);
        o_status.col_more     = (r_scan_col < eff_cols)
                              && (r_scan_idx >= {{(CW-scro_pkg::IDX_W){1'b0}}, ptr_val});
        o_status.out_full     = o_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= scro_pkg::ROW_W'(1);
            r_num_cols <= scro_pkg::COL_W'(1);
            r_num_nnz  <= '0;
            r_ptr_cnt  <= '0;
            r_nz_cnt   <= '0;
            r_emit_row <= CW'(1);
            r_scan_idx <= '0;
            r_scan_col <= CW'(1);
            r_out_pos  <= scro_pkg::POS_W'(1);
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    scro_pkg::REG_NUM_ROWS: r_num_rows <= i_cfg_data[scro_pkg::ROW_W-1:0];
                    scro_pkg::REG_NUM_COLS: r_num_cols <= i_cfg_data[scro_pkg::COL_W-1:0];
                    scro_pkg::REG_NUM_NNZ:  r_num_nnz  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load_ptr && r_ptr_cnt < CW'(MAX_COLS + 1)) begin
                r_ptr_cnt <= r_ptr_cnt + CW'(1);
            end
            if (i_cmd.load_nz && r_nz_cnt < CW'(MAX_NONZEROS)) begin
                r_nz_cnt <= r_nz_cnt + CW'(1);
            end
            if (i_cmd.restart) begin
                r_emit_row <= CW'(1);
                r_scan_idx <= '0;
                r_scan_col <= CW'(1);
                r_out_pos  <= scro_pkg::POS_W'(1);
            end
            if (i_cmd.out_take) begin
                o_out_valid <= 1'b0;
            end
            if (i_cmd.emit_end) begin
                o_out_valid <= 1'b1;
                o_kind      <= scro_pkg::KIND_END;
                o_row       <= scro_pkg::ROW_W'(eff_rows + CW'(1));
                o_col       <= '0;
                o_position  <= scro_pkg::POS_W'(eff_nnz + CW'(1));
                o_value_out <= '0;
            end
            if (i_cmd.emit_hdr) begin
                o_out_valid <= 1'b1;
                o_kind      <= scro_pkg::KIND_ROW_PTR;
                o_row       <= scro_pkg::ROW_W'(r_emit_row);
                o_col       <= '0;
                o_position  <= r_out_pos;
                o_value_out <= '0;
                r_scan_idx  <= CW'(1);
                r_scan_col  <= CW'(1);
            end
            if (i_cmd.next_row) begin
                r_emit_row <= r_emit_row + CW'(1);
                r_scan_idx <= '0;
            end
            if (i_cmd.scan_adv) begin
                r_scan_idx <= r_scan_idx + CW'(1);
            end
            if (i_cmd.col_adv) begin
                r_scan_col <= next_col;
            end
            if (i_cmd.emit_entry) begin
                o_out_valid <= 1'b1;
                o_kind      <= scro_pkg::KIND_ENTRY;
                o_row       <= scro_pkg::ROW_W'(r_emit_row);
                o_col       <= scro_pkg::COL_W'(r_scan_col);
                o_position  <= r_out_pos;
                o_value_out <= r_rd_val;
                r_out_pos   <= r_out_pos + scro_pkg::POS_W'(1);
                r_scan_idx  <= r_scan_idx + CW'(1);
            end
        end
    end
endmodule

>>> design/sparse_column_to_row_order_core.sv
// Top level of the sparse column-to-row order core: channels, config port, assertions.
// Depends on scro_pkg, scro_stream_if, scro_ctrl and scro_datapath.
//
//   channel  dir  handshake       payload
//   s_in     in   valid/ready     {cmd[76:75], index_value[74:64], value_bits[63:0]}
//   m_out    out  valid/ready     {kind[94:93], row[92:84], col[83:75],
//                                  position[74:64], value_out[63:0]}
//   cfg      in   i_cfg_we        i_cfg_idx, i_cfg_data (11 bits)
//
// Loads are stored as they are accepted. A fetch with a row header pending emits it
// from S_ROWCHK. Otherwise it reads and compares one stored row index at a time
// (registered read in S_SCAN_RD, then compare in S_SCAN_CHK); an entry then steps
// the columns (S_COL_RD, S_COL_CHK) and is loaded in S_OUT, and a fetch that runs off
// the end of a row goes back to S_ROWCHK for the next header or the end item. Every
// row rescans all stored entries, so a full conversion reads each entry once per row.
// A new request is taken only once the previous result has been drained from
// the output register. Reset is synchronous, active low; the stores need no
// clearing pass.
module sparse_column_to_row_order_core #(
    parameter int MAX_NONZEROS = scro_pkg::DEF_MAX_NONZEROS,
    parameter int MAX_COLS     = scro_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS     = scro_pkg::DEF_MAX_ROWS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    scro_stream_if.sink                     s_in,
    scro_stream_if.source                   m_out,
    input  logic                            i_cfg_we,
    input  logic [scro_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [scro_pkg::CFG_DAT_W-1:0]  i_cfg_data
);
    scro_pkg::t_cmd    cmd;
    scro_pkg::t_status status;
    logic [1:0]                 kind;
    logic [scro_pkg::ROW_W-1:0] row;
    logic [scro_pkg::COL_W-1:0] col;
    logic [scro_pkg::POS_W-1:0] pos;
    logic [scro_pkg::VAL_W-1:0] val;

    // controller: decode requests, sequence the scan
    scro_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_in.valid),
        .i_cmd      (s_in.payload[76:75]),
        .o_in_ready (s_in.ready),
        .i_status   (status),
        .i_out_ready(m_out.ready),
        .o_cmd      (cmd)
    );

    // datapath: stores, counters, output register
    scro_datapath #(
        .MAX_NONZEROS(MAX_NONZEROS),
        .MAX_COLS    (MAX_COLS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_index_value(s_in.payload[74:64]),
        .i_value_bits (s_in.payload[63:0]),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (m_out.valid),
        .o_kind       (kind),
        .o_row        (row),
        .o_col        (col),
        .o_position   (pos),
        .o_value_out  (val)
    );

    assign m_out.payload = {kind, row, col, pos, val};

`ifndef ASSERT_OFF
    // no request is taken while a result still waits
    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid |-> !s_in.ready)
        else $error("request accepted with result pending");
    // a result is loaded only into an empty output register
    a_emit_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit_end || cmd.emit_hdr || cmd.emit_entry) |-> !m_out.valid)
        else $error("result overwrote pending result");
    // at most one emit command per cycle
    a_one_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({cmd.emit_end, cmd.emit_hdr, cmd.emit_entry}) <= 1)
        else $error("multiple emits in one cycle");
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && !m_out.ready) |=> (m_out.valid && $stable(m_out.payload)))
        else $error("stalled result changed");
`endif
endmodule

>>> bench/sparse_column_to_row_order_core_test.sv
// Self-checking bench for sparse_column_to_row_order_core: drives load and fetch requests,
// predicts every row-ordered result and compares it field by field.
// Depends on scro_pkg, scro_stream_if and the core itself.
`timescale 1ns / 1ps

module sparse_column_to_row_order_core_test;
    localparam int  IN_W  = scro_pkg::CMD_W + scro_pkg::IDX_W + scro_pkg::VAL_W;
    localparam int  OUT_W = 2 + scro_pkg::ROW_W + scro_pkg::COL_W + scro_pkg::POS_W
                          + scro_pkg::VAL_W;
    localparam int  PTR_SLOTS   = scro_pkg::DEF_MAX_COLS + 1;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam logic [scro_pkg::CMD_W-1:0] CMD_RESERVED = 2'd3;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [scro_pkg::ROW_W-1:0] row;
        logic [scro_pkg::COL_W-1:0] col;
        logic [scro_pkg::POS_W-1:0] position;
        logic [scro_pkg::VAL_W-1:0] value_out;
    } t_result;

    typedef struct packed {
        logic [scro_pkg::CMD_W-1:0] cmd;
        logic [scro_pkg::IDX_W-1:0] index_value;
        logic [scro_pkg::VAL_W-1:0] value_bits;
    } t_request;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [scro_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [scro_pkg::CFG_DAT_W-1:0] i_cfg_data = '0;

    scro_stream_if #(.W(IN_W))  req_if ();
    scro_stream_if #(.W(OUT_W)) res_if ();

    sparse_column_to_row_order_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_in       (req_if),
        .m_out      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Shadow copy of the converter: registers, stores and scan state
    // ---------------------------------------------------------------
    int unsigned rows_reg = 1, cols_reg = 1, nnz_reg = 0;
    logic [scro_pkg::IDX_W-1:0] col_ptrs  [0:PTR_SLOTS];
    logic [scro_pkg::ROW_W-1:0] row_store [0:scro_pkg::DEF_MAX_NONZEROS];
    logic [scro_pkg::VAL_W-1:0] val_store [0:scro_pkg::DEF_MAX_NONZEROS];
    int unsigned ptr_loaded = 0, nz_loaded = 0;
    int unsigned emit_row = 1, scan_idx = 0, scan_col = 1;
    logic [scro_pkg::POS_W-1:0] out_pos = 1;

    t_request pending [$];
    t_result  expected_results [$];
    int failures = 0;
    int src_idle = 9, snk_idle = 68;
    logic hold_out = 1'b0;
    bit   pressure_go = 0;

    function automatic int unsigned sat(int unsigned v, int unsigned lim);
        return v > lim ? lim : v;
    endfunction

    function automatic void restart_scan();
        emit_row = 1;
        scan_idx = 0;
        scan_col = 1;
        out_pos  = 1;
    endfunction

    // pointer at a 1-based column slot; the slot after the last column is forced
    function automatic int unsigned ptr_at(int unsigned c, int unsigned nc, int unsigned nz);
        if (c == nc + 1)
            return nz + 1;
        if (c > PTR_SLOTS)
            return 0;
        return col_ptrs[c];
    endfunction

    // apply one accepted request; a fetch queues exactly one result
    function automatic void convert_request(t_request rq);
        int unsigned nr, nc, nz, i;
        bit done, found;
        t_result r;
        done = 0;
        case (rq.cmd)
            scro_pkg::CMD_LOAD_PTR: begin
                if (ptr_loaded < PTR_SLOTS) begin
                    col_ptrs[ptr_loaded + 1] = rq.index_value;
                    ptr_loaded++;
                end
                restart_scan();
            end
            scro_pkg::CMD_LOAD_NZ: begin
                if (nz_loaded < scro_pkg::DEF_MAX_NONZEROS) begin
                    row_store[nz_loaded + 1] = rq.index_value[scro_pkg::ROW_W-1:0];
                    val_store[nz_loaded + 1] = rq.value_bits;
                    nz_loaded++;
                end
                restart_scan();
            end
            scro_pkg::CMD_FETCH: begin
                nr = sat(rows_reg, scro_pkg::DEF_MAX_ROWS);
                nc = sat(cols_reg, scro_pkg::DEF_MAX_COLS);
                nz = sat(nnz_reg, scro_pkg::DEF_MAX_NONZEROS);
                while (!done) begin
                    if (emit_row > nr) begin
                        r = '{scro_pkg::KIND_END, scro_pkg::ROW_W'(nr + 1), '0,
                              scro_pkg::POS_W'(nz + 1), '0};
                        done = 1;
                    end else if (scan_idx == 0) begin
                        r = '{scro_pkg::KIND_ROW_PTR, scro_pkg::ROW_W'(emit_row), '0,
                              out_pos, '0};
                        scan_idx = 1;
                        scan_col = 1;
                        done = 1;
                    end else begin
                        found = 0;
                        for (i = scan_idx; i <= nz && !found; i++) begin
                            if (row_store[i] == emit_row) begin
                                while (scan_col < nc && i >= ptr_at(scan_col + 1, nc, nz))
                                    scan_col++;
                                r = '{scro_pkg::KIND_ENTRY, scro_pkg::ROW_W'(emit_row),
                                      scro_pkg::COL_W'(scan_col), out_pos, val_store[i]};
                                out_pos++;
                                scan_idx = i + 1;
                                found = 1;
                            end
                        end
                        if (found) begin
                            done = 1;
                        end else begin
                            emit_row++;
                            scan_idx = 0;
                        end
                    end
                end
                expected_results.push_back(r);
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Request driver: hold a request until taken, idle at random
    // ---------------------------------------------------------------
    initial begin
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        res_if.ready   = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready)
                convert_request(t_request'(req_if.payload));
            if (!req_if.valid || req_if.ready) begin
                if (pending.size() != 0 && $urandom_range(99) >= src_idle) begin
                    req_if.payload <= pending.pop_front();
                    req_if.valid   <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Result side: random back-pressure plus one long hold-off
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n)
            res_if.ready <= 1'b0;
        else
            res_if.ready <= !hold_out && ($urandom_range(99) >= snk_idle);
    end

    initial begin
        wait (pressure_go);
        @(posedge i_clk);
        hold_out <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_out <= 1'b0;
    end

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            failures++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = t_result'(res_if.payload);
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: %0h", res_if.payload);
                failures++;
            end else begin
                want = expected_results.pop_front();
                check_field("kind", want.kind, got.kind);
                check_field("row", want.row, got.row);
                check_field("col", want.col, got.col);
                check_field("position", want.position, got.position);
                check_field("value_out", want.value_out, got.value_out);
            end
        end
    end

    // Watchdog: end the run if it stalls
    int unsigned cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** sparse_column_to_row_order_core: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    int unsigned gen_ptrs = 0, gen_nzs = 0;

    task automatic push_request(logic [scro_pkg::CMD_W-1:0] cmd,
                                logic [scro_pkg::IDX_W-1:0] idx,
                                logic [scro_pkg::VAL_W-1:0] val);
        pending.push_back('{cmd, idx, val});
        if (cmd == scro_pkg::CMD_LOAD_PTR) gen_ptrs++;
        if (cmd == scro_pkg::CMD_LOAD_NZ)  gen_nzs++;
    endtask

    // hold until every request is taken and every result is back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending.size() != 0 || req_if.valid || expected_results.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_sizes(int unsigned nr, int unsigned nc, int unsigned nz);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= scro_pkg::REG_NUM_ROWS;
        i_cfg_data <= scro_pkg::CFG_DAT_W'(nr);
        rows_reg = nr & 'h1FF;
        @(posedge i_clk);
        i_cfg_idx <= scro_pkg::REG_NUM_COLS; i_cfg_data <= scro_pkg::CFG_DAT_W'(nc);
        cols_reg = nc & 'h1FF;
        @(posedge i_clk);
        i_cfg_idx <= scro_pkg::REG_NUM_NNZ; i_cfg_data <= scro_pkg::CFG_DAT_W'(nz);
        nnz_reg = nz & 'h7FF;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [scro_pkg::VAL_W-1:0] rand_value();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // top up the stores so that every slot a fetch reads has been loaded
    task automatic load_matrix(int unsigned nr, int unsigned nc, int unsigned nz);
        int unsigned step;
        step = nc == 0 ? 1 : (nz / nc) + 1;
        while (gen_ptrs < nc || $urandom_range(3) == 0) begin
            if ($urandom_range(7) == 0)
                push_request(scro_pkg::CMD_LOAD_PTR, scro_pkg::IDX_W'($urandom), '0);
            else
                push_request(scro_pkg::CMD_LOAD_PTR,
                             scro_pkg::IDX_W'(1 + gen_ptrs * $urandom_range(step)), '0);
        end
        while (gen_nzs < nz || $urandom_range(3) == 0) begin
            if ($urandom_range(9) == 0)
                push_request(scro_pkg::CMD_LOAD_NZ, scro_pkg::IDX_W'($urandom), rand_value());
            else
                push_request(scro_pkg::CMD_LOAD_NZ,
                             scro_pkg::IDX_W'($urandom_range(nr + 1, 1)), rand_value());
        end
    endtask

    // one conversion: sizes, loads, then a stream of fetches with some noise
    task automatic run_matrix(int unsigned nr, int unsigned nc, int unsigned nz,
                              int unsigned fetches);
        int unsigned sr, sc, sz;
        wait_drained();
        write_sizes(nr, nc, nz);
        sr = sat(nr & 'h1FF, scro_pkg::DEF_MAX_ROWS);
        sc = sat(nc & 'h1FF, scro_pkg::DEF_MAX_COLS);
        sz = sat(nz & 'h7FF, scro_pkg::DEF_MAX_NONZEROS);
        load_matrix(sr, sc, sz);
        repeat (fetches) begin
            case ($urandom_range(39))
                0:       push_request(CMD_RESERVED, scro_pkg::IDX_W'($urandom), rand_value());
                1:       push_request(scro_pkg::CMD_LOAD_NZ,
                                      scro_pkg::IDX_W'($urandom_range(sr + 1)), rand_value());
                2:       push_request(scro_pkg::CMD_LOAD_PTR, scro_pkg::IDX_W'($urandom), '0);
                default: push_request(scro_pkg::CMD_FETCH, scro_pkg::IDX_W'($urandom),
                                      rand_value());
            endcase
        end
    endtask

    initial begin
        int unsigned nr, nz;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset sizes give one header and then the end item, repeated
        push_request(scro_pkg::CMD_FETCH, '0, '0);
        push_request(scro_pkg::CMD_FETCH, '1, '1);
        push_request(scro_pkg::CMD_FETCH, '0, '0);
        push_request(CMD_RESERVED, '1, '1);
        push_request(scro_pkg::CMD_FETCH, '0, '0);
        wait_drained();
        // small matrix: forced last pointer, a masked row index, extreme values
        write_sizes(2, 2, 3);
        push_request(scro_pkg::CMD_LOAD_PTR, 11'd1, '0);
        push_request(scro_pkg::CMD_LOAD_PTR, 11'd3, '0);
        push_request(scro_pkg::CMD_LOAD_PTR, 11'h7FF, '0);
        push_request(scro_pkg::CMD_LOAD_NZ, 11'd2, '1);
        push_request(scro_pkg::CMD_LOAD_NZ, 11'd1, '0);
        push_request(scro_pkg::CMD_LOAD_NZ, 11'h601, 64'h8000_0000_0000_0001);
        repeat (9) push_request(scro_pkg::CMD_FETCH, '0, '0);
        push_request(scro_pkg::CMD_LOAD_PTR, 11'd4, '0);
        push_request(scro_pkg::CMD_FETCH, '0, '0);

        // Random: small matrices, idle pattern changes by thirds
        for (int ph = 0; ph < 18; ph++) begin
            if (ph == 6) begin
                wait_drained();
                src_idle = 68; snk_idle = 9;
            end else if (ph == 12) begin
                wait_drained();
                src_idle = 0; snk_idle = 0;
            end
            nr = $urandom_range(12) == 0 ? 0 : $urandom_range(12, 1);
            nz = $urandom_range(16);
            run_matrix(nr, $urandom_range(8, 1), nz, nr + nz + $urandom_range(4, 2));
            if (ph == 1)
                pressure_go = 1;
        end

        // saturated row count, no entries: fetches step through the row headers
        run_matrix(511, 4, 0, 258);

        // no rows, saturated column and entry counts: end items with the clamped count
        wait_drained();
        write_sizes(0, 511, 2047);
        repeat (4) push_request(scro_pkg::CMD_FETCH, '0, '0);
        wait_drained();
        repeat (20) @(posedge i_clk);

        if (failures == 0)
            $display("** sparse_column_to_row_order_core: PASSED **");
        else
            $display("** sparse_column_to_row_order_core: FAILED **");
        $finish;
    end
endmodule
